// ===== rtl/core/mfd_pkg.sv =====
// Package for the mailbox fabric doorbell block.
// Request/result word types and status codes; no dependencies.
package mfd_pkg;

    localparam int TDATA_IN_W  = 96;   // 94 bits of fields, padded to whole bytes
    localparam int TDATA_OUT_W = 128;  // 124 bits of fields, padded to whole bytes

    typedef enum logic [2:0] {
        ST_SENT    = 3'd0,
        ST_BADARG  = 3'd1,
        ST_FULL    = 3'd2,
        ST_DELIV   = 3'd3,
        ST_NONE    = 3'd4,
        ST_STALE   = 3'd5
    } status_t;

    localparam logic [7:0] CONTROL_TYPE = 8'd1;

    typedef struct packed {
        logic        req_type;
        logic [2:0]  src;
        logic [2:0]  dst;
        logic [7:0]  msg_type;
        logic [7:0]  msg_mode;
        logic [7:0]  length;
        logic [63:0] data;
        logic        bad;
    } req_t;

    typedef struct packed {
        status_t     status;
        logic [2:0]  out_src;
        logic [7:0]  out_type;
        logic [7:0]  out_mode;
        logic [3:0]  out_length;
        logic [63:0] out_data;
        logic        more_pending;
        logic        stopped;
        logic [31:0] processed_count;
    } res_t;

endpackage

// ===== rtl/core/mfd_front.sv =====
// Front end: accepts request words, checks ids and length, queues them.
// Depends on mfd_pkg.
module mfd_front #(
    parameter int AGENTS        = 8,
    parameter int PAYLOAD_BYTES = 8,
    parameter int QDEPTH        = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  mfd_pkg::req_t    in_req,
    input  logic [3:0]       agent_count,
    output logic             q_valid,
    input  logic             q_ready,
    output mfd_pkg::req_t    q_req
);
    import mfd_pkg::*;

    localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

    req_t          q_mem [QDEPTH];
    logic [PW-1:0] wp_reg, wp_next, rp_reg, rp_next;
    logic [PW:0]   cnt_reg, cnt_next;
    logic          push, pop, bad;
    req_t          cls;

    always_comb
    begin
        bad = ({1'b0, in_req.dst} >= agent_count) || (32'(in_req.dst) >= 32'(AGENTS));
        if (!in_req.req_type)
        begin
            bad = bad || ({1'b0, in_req.src} >= agent_count)
                || (32'(in_req.src) >= 32'(AGENTS)) || (in_req.length == 8'd0)
                || ({24'd0, in_req.length} > 32'(PAYLOAD_BYTES));
        end
        cls     = in_req;
        cls.bad = bad;
    end

    assign in_ready = (cnt_reg != (PW+1)'(QDEPTH));
    assign q_valid  = (cnt_reg != '0);
    assign q_req    = q_mem[rp_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;

    always_comb
    begin
        wp_next  = push ? ((wp_reg == PW'(QDEPTH-1)) ? '0 : wp_reg + 1'b1) : wp_reg;
        rp_next  = pop ? ((rp_reg == PW'(QDEPTH-1)) ? '0 : rp_reg + 1'b1) : rp_reg;
        cnt_next = cnt_reg + (PW+1)'(push) - (PW+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wp_reg] <= cls;
        end
    end

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= (PW+1)'(QDEPTH)) else $error("queue overflow");
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == (PW+1)'(QDEPTH)) |-> !in_ready) else $error("push when full");
    a_empty_invalid: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == '0) |-> !q_valid) else $error("valid when empty");

endmodule

// ===== rtl/core/mfd_back.sv =====
// Back end: executes send/service requests against ring slot memories.
// Depends on mfd_pkg.
module mfd_back #(
    parameter int AGENTS     = 8,
    parameter int RING_DEPTH = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          q_valid,
    output logic          q_ready,
    input  mfd_pkg::req_t q_req,
    output logic          res_valid,
    input  logic          res_ready,
    output mfd_pkg::res_t res
);
    import mfd_pkg::*;

    localparam int AW    = (AGENTS > 1) ? $clog2(AGENTS) : 1;
    localparam int DW    = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int RW    = 2 * AW;
    localparam int SW    = RW + DW;
    localparam int NR    = 1 << RW;
    localparam int NS    = 1 << SW;

    typedef enum logic [5:0] {
        S_CLR  = 6'b000001,
        S_IDLE = 6'b000010,
        S_RD   = 6'b000100,
        S_SLOT = 6'b001000,
        S_EXE  = 6'b010000,
        S_OUT  = 6'b100000
    } state_t;

    // per ring: read pointer and occupancy; write pointer is read pointer + occupancy
    typedef struct packed {
        logic [DW-1:0] rptr;
        logic [DW:0]   cnt;
    } ring_t;

    state_t            state_reg, state_next;
    req_t              r_reg;
    logic [AGENTS-1:0] mask_reg [AGENTS];
    ring_t             ring_mem [NR];
    ring_t             rs_reg;
    ring_t             rs_next;
    logic [RW-1:0]     clr_reg;
    logic [19:0]       hdr_mem [NS];
    logic [63:0]       dat_mem [NS];
    logic [19:0]       hdr_rd_reg;
    logic [63:0]       dat_rd_reg;
    logic [AW-1:0]     s_reg;
    logic              found_reg;
    logic              stop_reg;
    logic [31:0]       total_reg;
    res_t              res_reg, res_next;
    logic [RW-1:0]     ring;
    logic [DW:0]       wsum;
    logic [DW-1:0]     wptr, nptr;
    logic [SW-1:0]     widx, ridx;
    logic              full, empty, more, stop_hit;
    logic              do_send, do_pop, do_stale;
    logic [AW-1:0]     lsb;
    logic              any;
    logic [AW-1:0]     dsti, srci, rdst;
    logic [63:0]       bmask;

    assign dsti = AW'(q_req.dst);
    assign rdst = AW'(r_reg.dst);
    assign srci = AW'(r_reg.src);

    always_comb
    begin
        lsb = '0;
        any = 1'b0;
        for (int i = AGENTS-1; i >= 0; i--)
        begin
            if (mask_reg[dsti][i])
            begin
                lsb = AW'(i);
                any = 1'b1;
            end
        end
    end

    assign ring = r_reg.req_type ? {s_reg, rdst} : {srci, rdst};

    always_comb
    begin
        wsum = {1'b0, rs_reg.rptr} + rs_reg.cnt;
        wptr = (wsum >= (DW+1)'(RING_DEPTH)) ? DW'(wsum - (DW+1)'(RING_DEPTH)) : DW'(wsum);
    end

    assign nptr  = (rs_reg.rptr == DW'(RING_DEPTH-1)) ? '0 : rs_reg.rptr + 1'b1;
    assign widx  = {ring, wptr};
    assign ridx  = {ring, rs_reg.rptr};
    assign full  = (rs_reg.cnt == (DW+1)'(RING_DEPTH));
    assign empty = (rs_reg.cnt == '0);
    assign more  = (rs_reg.cnt > (DW+1)'(1));

    assign do_send  = !r_reg.bad && !r_reg.req_type && !full;
    assign do_pop   = !r_reg.bad && r_reg.req_type && found_reg && !empty;
    assign do_stale = !r_reg.bad && r_reg.req_type && found_reg && empty;
    assign stop_hit = do_pop && (hdr_rd_reg[19:12] == CONTROL_TYPE)
                      && (dat_rd_reg[7:0] == 8'd0);

    assign q_ready   = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_OUT);
    assign res       = res_reg;

    always_comb
    begin
        bmask = '1;
        if (r_reg.length < 8'd8)
        begin
            bmask = (64'd1 << {r_reg.length[2:0], 3'b000}) - 64'd1;
        end
    end

    always_comb
    begin
        rs_next = rs_reg;
        if (do_send)
        begin
            rs_next.cnt = rs_reg.cnt + 1'b1;
        end
        if (do_pop)
        begin
            rs_next.rptr = nptr;
            rs_next.cnt  = rs_reg.cnt - 1'b1;
        end
    end

    always_comb
    begin
        res_next                 = '0;
        res_next.stopped         = stop_reg || stop_hit;
        res_next.processed_count = total_reg;
        if (r_reg.bad)
            res_next.status = ST_BADARG;
        else if (!r_reg.req_type)
            res_next.status = full ? ST_FULL : ST_SENT;
        else if (!found_reg)
            res_next.status = ST_NONE;
        else if (empty)
            res_next.status = ST_STALE;
        else
        begin
            res_next.status          = ST_DELIV;
            res_next.out_src         = 3'(s_reg);
            res_next.out_type        = hdr_rd_reg[19:12];
            res_next.out_mode        = hdr_rd_reg[11:4];
            res_next.out_length      = hdr_rd_reg[3:0];
            res_next.out_data        = dat_rd_reg;
            res_next.more_pending    = more;
            res_next.processed_count = total_reg + 32'd1;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLR:  if (clr_reg == RW'(NR-1)) state_next = S_IDLE;
            S_IDLE: if (q_valid) state_next = S_RD;
            S_RD:   state_next = S_SLOT;
            S_SLOT: state_next = S_EXE;
            S_EXE:  state_next = S_OUT;
            S_OUT:  if (res_ready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLR;
            clr_reg   <= '0;
            for (int i = 0; i < AGENTS; i++) mask_reg[i] <= '0;
            stop_reg  <= 1'b0;
            total_reg <= '0;
            s_reg     <= '0;
            found_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_CLR)
            begin
                clr_reg <= clr_reg + 1'b1;
            end
            if (state_reg == S_IDLE && q_valid)
            begin
                s_reg     <= lsb;
                found_reg <= any;
            end
            if (state_reg == S_EXE)
            begin
                if (do_send)
                    mask_reg[rdst][srci] <= 1'b1;
                if (do_stale || (do_pop && !more))
                    mask_reg[rdst][s_reg] <= 1'b0;
                if (do_pop)
                    total_reg <= total_reg + 32'd1;
                if (stop_hit)
                    stop_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && q_valid)
        begin
            r_reg <= q_req;
        end
        if (state_reg == S_CLR)
        begin
            ring_mem[clr_reg] <= '0;
        end
        else if (state_reg == S_EXE && (do_send || do_pop))
        begin
            ring_mem[ring] <= rs_next;
        end
        if (state_reg == S_RD)
        begin
            rs_reg <= ring_mem[ring];
        end
        if (state_reg == S_SLOT)
        begin
            hdr_rd_reg <= hdr_mem[ridx];
            dat_rd_reg <= dat_mem[ridx];
        end
        if (state_reg == S_EXE && do_send)
        begin
            hdr_mem[widx] <= {r_reg.msg_type, r_reg.msg_mode, r_reg.length[3:0]};
            dat_mem[widx] <= r_reg.data & bmask;
        end
        if (state_reg == S_EXE)
        begin
            res_reg <= res_next;
        end
    end

    a_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg)) else $error("state not onehot");
    a_stop_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        stop_reg |=> stop_reg) else $error("stop flag cleared");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res_ready) |=> res_valid) else $error("result dropped");

endmodule

// ===== rtl/core/mailbox_fabric_doorbell.sv =====
// Top level of the mailbox fabric doorbell block.
// Instantiates mfd_front and mfd_back; depends on mfd_pkg.
//
// One result word per request word, in order. After reset the back end clears
// its per-ring pointer table, one ring per cycle (64 rings for 8 agents); request
// words are queued meanwhile. Each request then passes through the back-end steps
// latch, ring pointer read, slot read, update and result. The back end takes no
// new request until the result has been handed off. The two-word front queue
// keeps accepting while it has room and the back end works.
module mailbox_fabric_doorbell #(
    parameter int AGENTS        = 8,
    parameter int RING_DEPTH    = 16,
    parameter int PAYLOAD_BYTES = 8
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [mfd_pkg::TDATA_IN_W-1:0]  s_axis_tdata,  // src,dst,msg_type,msg_mode,
                                                           // length,data,pad
    input  logic                            s_axis_tuser,  // req_type
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [mfd_pkg::TDATA_OUT_W-1:0] m_axis_tdata,  // status,out_src,out_type,
                                                           // out_mode,out_length,out_data,
                                                           // more_pending,stopped,
                                                           // processed_count,pad
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [3:0]                      cfg_data       // agent_count
);
    import mfd_pkg::*;

    logic [3:0] agent_count_reg;
    req_t       in_req, q_req;
    logic       q_valid, q_ready;
    res_t       res;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            agent_count_reg <= 4'd8;
        else if (cfg_valid)
            agent_count_reg <= cfg_data;
    end

    always_comb
    begin
        in_req.req_type = s_axis_tuser;
        in_req.src      = s_axis_tdata[2:0];
        in_req.dst      = s_axis_tdata[5:3];
        in_req.msg_type = s_axis_tdata[13:6];
        in_req.msg_mode = s_axis_tdata[21:14];
        in_req.length   = s_axis_tdata[29:22];
        in_req.data     = s_axis_tdata[93:30];
        in_req.bad      = 1'b0;
    end

    mfd_front #(.AGENTS(AGENTS), .PAYLOAD_BYTES(PAYLOAD_BYTES), .QDEPTH(2)) u_front (
        .clk, .rst_n,
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_req,
        .agent_count(agent_count_reg),
        .q_valid, .q_ready, .q_req
    );

    mfd_back #(.AGENTS(AGENTS), .RING_DEPTH(RING_DEPTH)) u_back (
        .clk, .rst_n,
        .q_valid, .q_ready, .q_req,
        .res_valid(m_axis_tvalid), .res_ready(m_axis_tready), .res
    );

    assign m_axis_tdata = {4'd0, res.processed_count, res.stopped, res.more_pending,
        res.out_data, res.out_length, res.out_mode, res.out_type, res.out_src, res.status};

endmodule
